[src/lsu_pkg.sv]
// lsu_pkg: shared types and constants for the load/store unit
// no dependencies
package lsu_pkg;

    localparam int unsigned MEM_BYTES   = 2097152;
    localparam int unsigned MEM_AW      = $clog2(MEM_BYTES);
    localparam int unsigned MEM_WORDS   = MEM_BYTES / 8;
    localparam int unsigned WORD_AW     = MEM_AW - 3;
    localparam int unsigned NUM_REGS    = 31;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_BAD_ENC = 2'd1,
        ST_OUT_MEM = 2'd2
    } status_t;

    // clear state machine
    typedef enum logic [2:0] {
        CS_CLEAR = 3'b001,
        CS_RUN   = 3'b010,
        CS_WAIT  = 3'b100
    } clr_state_t;

    // classified instruction handed from front to back
    typedef struct packed {
        logic        bad;
        logic        literal;
        logic        load;
        logic        sf;
        logic [1:0]  mode;     // 0 uimm, 1 reg, 2 pre, 3 post
        logic [4:0]  rt;
        logic [4:0]  rn;
        logic [4:0]  rm;
        logic [63:0] imm;      // scaled/sign-extended offset
        logic [63:0] pc;
    } lsu_op_t;

    localparam logic [1:0] MD_UIMM = 2'd0;
    localparam logic [1:0] MD_REG  = 2'd1;
    localparam logic [1:0] MD_PRE  = 2'd2;
    localparam logic [1:0] MD_POST = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_load;
        logic [63:0] access_address;
        logic [63:0] transfer_data;
        logic [4:0]  target_register;
    } lsu_res_t;

endpackage

[src/load_store_unit.sv]
// load_store_unit: aarch64 ldr/str execution unit, top level
// depends on lsu_pkg, lsu_decode, lsu_execute
// pipeline: queue, execute (operands, address and memory words registered), retire (result
// register); queued instructions wait while the back part is busy with the one ahead
// the back part takes a new instruction only after the last has retired, and a stalled result holds it
// reset: aresetn synchronous active low; register file zeroed at once, then a clearing
// pass over all MEM_BYTES/8 words zeroes data memory, during which the back part takes nothing
module load_store_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,   // instruction[31:0], program_counter[95:32]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [135:0]  m_tdata    // status[1:0], is_load[2], access_address[66:3],
                                     // transfer_data[130:67], target_register[135:131]
);
    import lsu_pkg::*;

    lsu_op_t  op;
    lsu_res_t res;
    logic     op_valid, op_ready;

    // front: classify and queue
    lsu_decode u_dec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .ins      (s_tdata[31:0]),
        .pc       (s_tdata[95:32]),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    // back: execute against register file and memory
    lsu_execute u_exe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // pack the result transfer, low field first
    assign m_tdata = {res.target_register, res.transfer_data, res.access_address,
                      res.is_load, res.status};
endmodule

[src/lsu_decode.sv]
// lsu_decode: front part, classifies instruction words into ops
// depends on lsu_pkg
module lsu_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [31:0]       ins,
    input  logic [63:0]       pc,
    output logic              op_valid,
    input  logic              op_ready,
    output lsu_pkg::lsu_op_t  op
);
    import lsu_pkg::*;

    lsu_op_t q_reg [QUEUE_DEPTH];
    logic    wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    lsu_op_t d;
    logic push, pop;

    always_comb begin
        d = '0;
        d.bad     = (ins[28:25] & 4'd5) != 4'd4;
        d.literal = !ins[31];
        d.sf      = ins[30];
        d.load    = ins[31] ? ins[22] : 1'b1;
        d.rt      = ins[4:0];
        d.rn      = ins[9:5];
        d.rm      = ins[20:16];
        d.pc      = pc;
        if (!ins[31]) begin
            d.imm  = {{43{ins[23]}}, ins[23:5], 2'b00};
            d.mode = MD_UIMM;
        end else if (ins[24]) begin
            d.imm  = ins[30] ? {49'd0, ins[21:10], 3'd0} : {50'd0, ins[21:10], 2'd0};
            d.mode = MD_UIMM;
        end else if (ins[21]) begin
            d.mode = MD_REG;
        end else begin
            d.imm  = {{55{ins[20]}}, ins[20:12]};
            d.mode = ins[11] ? MD_PRE : MD_POST;
        end
    end

    assign in_ready = cnt_reg != 2'(QUEUE_DEPTH);
    assign op_valid = cnt_reg != 2'd0;
    assign op       = q_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = op_valid && op_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= d;
        end
    end

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'(QUEUE_DEPTH) && !pop) |=> cnt_reg == 2'(QUEUE_DEPTH))
        else $error("full queue lost entry");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !op_valid) else $error("valid while empty");
endmodule

[src/lsu_execute.sv]
// lsu_execute: back part, register file, data memory and result register
// depends on lsu_pkg
module lsu_execute (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              op_valid,
    output logic              op_ready,
    input  lsu_pkg::lsu_op_t  op,
    output logic              res_valid,
    input  logic              res_ready,
    output lsu_pkg::lsu_res_t res
);
    import lsu_pkg::*;

    logic [63:0] rf_reg [NUM_REGS];
    logic [63:0] mem    [MEM_WORDS];

    clr_state_t  st_reg, st_next;
    logic [WORD_AW-1:0] clr_reg, clr_next;

    lsu_op_t     op_reg;
    logic [63:0] addr_reg, wbv_reg;
    logic        inmem_reg, wb_reg;
    logic [WORD_AW-1:0] w0_reg;
    logic [63:0] d0_reg, d1_reg;
    lsu_res_t    res_reg;
    logic        res_valid_reg;

    logic [63:0] base, roff, addr, wbv, lim;
    logic        wb, inmem, accept, out_free;
    logic [MEM_AW-1:0]  a_lo;
    logic [WORD_AW-1:0] w0, w1;
    logic [127:0] pair, shifted;
    logic [63:0]  ldv, rtv, stv;
    logic [127:0] wdat, wmask;

    function automatic logic [63:0] rd(input logic [63:0] f [NUM_REGS], input logic [4:0] i);
        rd = (i == 5'd31) ? 64'd0 : f[i];
    endfunction

    // execute on accept: base read, address and both memory words registered; retire in CS_WAIT
    assign out_free = !res_valid_reg || res_ready;
    assign op_ready = (st_reg == CS_RUN);
    assign accept   = op_valid && op_ready;

    always_comb begin
        base  = op.literal ? op.pc : rd(rf_reg, op.rn);
        roff  = (op.mode == MD_REG && !op.literal) ? rd(rf_reg, op.rm) : op.imm;
        addr  = (op.mode == MD_POST && !op.literal) ? base : base + roff;
        wbv   = base + op.imm;
        wb    = !op.literal && (op.mode == MD_PRE || op.mode == MD_POST);
        lim   = 64'(MEM_BYTES) - (op.sf ? 64'd8 : 64'd4);
        inmem = addr <= lim;
        a_lo  = addr[MEM_AW-1:0];
        w0    = a_lo[MEM_AW-1:3];
        w1    = w0 + WORD_AW'(1);
    end

    // read both words while the address is registered
    always_ff @(posedge aclk) begin
        if (accept) begin
            d0_reg <= mem[w0];
            d1_reg <= mem[w1];
        end
    end

    always_comb begin
        pair    = {d1_reg, d0_reg};
        shifted = pair >> {addr_reg[2:0], 3'b000};
        ldv     = op_reg.sf ? shifted[63:0] : {32'd0, shifted[31:0]};
        // the write-back to the base lands first, except on the zero register
        rtv     = (wb_reg && op_reg.rt == op_reg.rn && op_reg.rn != 5'd31)
                  ? wbv_reg : rd(rf_reg, op_reg.rt);
        stv     = op_reg.sf ? rtv : {32'd0, rtv[31:0]};
        wdat    = {64'd0, stv} << {addr_reg[2:0], 3'b000};
        wmask   = (op_reg.sf ? {64'd0, {64{1'b1}}} : {96'd0, {32{1'b1}}})
                  << {addr_reg[2:0], 3'b000};
    end

    always_comb begin
        st_next  = st_reg;
        clr_next = clr_reg;
        unique case (st_reg)
            CS_CLEAR: begin
                clr_next = clr_reg + WORD_AW'(1);
                if (clr_reg == WORD_AW'(MEM_WORDS - 1)) st_next = CS_RUN;
            end
            CS_RUN:  if (accept) st_next = CS_WAIT;
            CS_WAIT: if (out_free) st_next = CS_RUN;
            default: st_next = CS_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= CS_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            st_reg  <= st_next;
            clr_reg <= clr_next;
            if (st_reg == CS_WAIT && out_free) res_valid_reg <= 1'b1;
            else if (res_ready) res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= op;
            addr_reg  <= addr;
            wbv_reg   <= wbv;
            wb_reg    <= wb;
            inmem_reg <= inmem;
            w0_reg    <= w0;
        end
    end

    // retire: memory and register writes, result capture; the memory block also clears during CS_CLEAR
    always_ff @(posedge aclk) begin
        if (st_reg == CS_CLEAR) begin
            mem[clr_reg] <= 64'd0;
        end else if (st_reg == CS_WAIT && out_free && !op_reg.bad && inmem_reg
                     && !op_reg.load) begin
            mem[w0_reg] <= (d0_reg & ~wmask[63:0]) | (wdat[63:0] & wmask[63:0]);
            mem[w0_reg + WORD_AW'(1)] <= (d1_reg & ~wmask[127:64])
                                        | (wdat[127:64] & wmask[127:64]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) rf_reg[i] <= 64'd0;
        end else if (st_reg == CS_WAIT && out_free && !op_reg.bad && inmem_reg) begin
            if (wb_reg && op_reg.rn != 5'd31) rf_reg[op_reg.rn] <= wbv_reg;
            if (op_reg.load && op_reg.rt != 5'd31) rf_reg[op_reg.rt] <= ldv;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == CS_WAIT && out_free) begin
            if (op_reg.bad) begin
                res_reg <= '{status: ST_BAD_ENC, default: '0};
            end else begin
                res_reg.status          <= inmem_reg ? ST_DONE : ST_OUT_MEM;
                res_reg.is_load         <= op_reg.load;
                res_reg.access_address  <= addr_reg;
                res_reg.transfer_data   <= !inmem_reg ? 64'd0 : (op_reg.load ? ldv : stv);
                res_reg.target_register <= op_reg.rt;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_noacc: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == CS_CLEAR |-> !accept) else $error("accept during clear");
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> st_reg == CS_WAIT) else $error("missed execute");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> $stable(res)) else $error("result changed");
endmodule

[tb/load_store_unit_tb.sv]
// load_store_unit_tb: self-checking testbench for the load/store unit
// depends on lsu_pkg and load_store_unit; holds its own register file and memory image
module load_store_unit_tb;
    import lsu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // scoreboard: mirrors the architectural state and queues expected results
    class ldst_scoreboard;
        logic [63:0] xregs [NUM_REGS];
        bit   [7:0]  mem_image [bit [63:0]];
        lsu_res_t    expected_results [$];

        function new();
            foreach (xregs[i]) xregs[i] = '0;
        endfunction

        function logic [63:0] xread(logic [4:0] idx);
            return (idx < NUM_REGS) ? xregs[idx] : 64'd0;
        endfunction

        function void xwrite(logic [4:0] idx, logic [63:0] v);
            if (idx < NUM_REGS) xregs[idx] = v;
        endfunction

        function bit [7:0] byte_at(logic [63:0] a);
            return mem_image.exists(a) ? mem_image[a] : 8'd0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // predict the result of one accepted instruction and update the mirror
        function void note_instruction(logic [31:0] ins, logic [63:0] pc);
            lsu_res_t    e;
            logic [63:0] base, addr, off, wb_val, data;
            logic [63:0] sz;
            bit          ld, wb;
            e = '0;
            e.status = ST_BAD_ENC;
            wb = 0;
            wb_val = '0;
            if ((ins[28:25] & 4'd5) != 4'd4) begin
                expected_results.push_back(e);
                return;
            end
            sz = ins[30] ? 64'd8 : 64'd4;
            if (ins[31]) begin
                base = xread(ins[9:5]);
                ld = ins[22];
                if (ins[24]) begin
                    addr = base + {52'd0, ins[21:10]} * sz;
                end else if (ins[21]) begin
                    addr = base + xread(ins[20:16]);
                end else begin
                    off = {{55{ins[20]}}, ins[20:12]};
                    wb = 1;
                    if (ins[11]) begin
                        addr = base + off;
                        wb_val = addr;
                    end else begin
                        addr = base;
                        wb_val = base + off;
                    end
                end
            end else begin
                // literal: signed word offset from the instruction address
                off = {{43{ins[23]}}, ins[23:5], 2'b00};
                ld = 1;
                addr = pc + off;
            end
            e.is_load = ld;
            e.access_address = addr;
            e.target_register = ins[4:0];
            if (addr > 64'(MEM_BYTES) - sz) begin
                e.status = ST_OUT_MEM;
                expected_results.push_back(e);
                return;
            end
            // write-back lands before the access
            if (wb) xwrite(ins[9:5], wb_val);
            data = '0;
            if (ld) begin
                for (int i = 0; i < sz; i++) data |= 64'(byte_at(addr + i)) << (8 * i);
                xwrite(ins[4:0], data);
            end else begin
                data = xread(ins[4:0]);
                if (!ins[30]) data[63:32] = '0;
                for (int i = 0; i < sz; i++) mem_image[addr + i] = data[8*i +: 8];
            end
            e.status = ST_DONE;
            e.transfer_data = data;
            expected_results.push_back(e);
        endfunction

        // compare one result with the oldest expectation; mismatches go to msgs
        function void check_result(lsu_res_t got, ref string msgs[$]);
            lsu_res_t w;
            msgs.delete();
            if (expected_results.size() == 0) begin
                msgs.push_back("result transfer with nothing expected");
                return;
            end
            w = expected_results.pop_front();
            if (got.status != w.status)
                msgs.push_back($sformatf("status %0d want %0d", got.status, w.status));
            if (got.is_load != w.is_load)
                msgs.push_back($sformatf("is_load %0d want %0d", got.is_load, w.is_load));
            if (got.access_address != w.access_address)
                msgs.push_back($sformatf("address %h want %h",
                                         got.access_address, w.access_address));
            if (got.transfer_data != w.transfer_data)
                msgs.push_back($sformatf("data %h want %h",
                                         got.transfer_data, w.transfer_data));
            if (got.target_register != w.target_register)
                msgs.push_back($sformatf("rt %0d want %0d",
                                         got.target_register, w.target_register));
        endfunction
    endclass

    logic          aclk = 0;
    logic          aresetn = 0;
    logic          s_tvalid = 0;
    logic          s_tready;
    logic [95:0]   s_tdata = '0;   // instruction[31:0], program_counter[95:32]
    logic          m_tvalid;
    logic          m_tready = 0;
    logic [135:0]  m_tdata;        // status, is_load, access_address, transfer_data, rt

    ldst_scoreboard sb = new();
    int  errors = 0;
    int  sent = 0;
    bit  hold_request = 0;
    bit  no_idle = 0;

    load_store_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    task automatic flag_mismatch(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    // mostly short gaps, a few long ones, none during a burst stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // instruction builders; bits the unit ignores stay random
    function automatic logic [31:0] mk_uimm(bit sf, bit ld, logic [11:0] imm,
                                            logic [4:0] rn, logic [4:0] rt);
        logic [31:0] ins;
        ins = $urandom;
        ins[31] = 1; ins[30] = sf; ins[27] = 1; ins[25] = 0; ins[24] = 1;
        ins[22] = ld; ins[21:10] = imm; ins[9:5] = rn; ins[4:0] = rt;
        return ins;
    endfunction

    function automatic logic [31:0] mk_regoff(bit sf, bit ld, logic [4:0] rm,
                                              logic [4:0] rn, logic [4:0] rt);
        logic [31:0] ins;
        ins = $urandom;
        ins[31] = 1; ins[30] = sf; ins[27] = 1; ins[25] = 0; ins[24] = 0;
        ins[22] = ld; ins[21] = 1; ins[20:16] = rm; ins[9:5] = rn; ins[4:0] = rt;
        return ins;
    endfunction

    function automatic logic [31:0] mk_index(bit sf, bit ld, logic [8:0] simm, bit pre,
                                             logic [4:0] rn, logic [4:0] rt);
        logic [31:0] ins;
        ins = $urandom;
        ins[31] = 1; ins[30] = sf; ins[27] = 1; ins[25] = 0; ins[24] = 0;
        ins[22] = ld; ins[21] = 0; ins[20:12] = simm; ins[11] = pre;
        ins[9:5] = rn; ins[4:0] = rt;
        return ins;
    endfunction

    function automatic logic [31:0] mk_literal(bit sf, logic [18:0] imm, logic [4:0] rt);
        logic [31:0] ins;
        ins = $urandom;
        ins[31] = 0; ins[30] = sf; ins[27] = 1; ins[25] = 0;
        ins[23:5] = imm; ins[4:0] = rt;
        return ins;
    endfunction

    // offer one instruction and wait for its transfer
    task automatic send(logic [31:0] ins, logic [63:0] pc);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {pc, ins};
        do @(posedge aclk); while (!s_tready);
        sb.note_instruction(ins, pc);
        sent++;
        if (sent == 150) hold_request = 1;
        if (sent % 60 == 0) no_idle = ($urandom_range(0, 2) == 0);
    endtask

    function automatic logic [4:0] pick_reg();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 5'd31;
        if (r < 8) return 5'($urandom_range(0, 7));
        return 5'($urandom);
    endfunction

    function automatic logic [63:0] pick_pc();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 64'($urandom_range(0, MEM_BYTES - 1));
        if (r < 9) return 64'(MEM_BYTES) - 64'($urandom_range(0, 16));
        return {$urandom, $urandom};
    endfunction

    function automatic logic [8:0] pick_simm();
        if ($urandom_range(0, 3) == 0) return 9'($urandom);
        return 9'($urandom_range(0, 32));
    endfunction

    // result side: random back-pressure plus one long hold-off
    initial begin
        int stall_left;
        int idle_left;
        bit held;
        lsu_res_t got;
        string msgs [$];
        stall_left = 0;
        idle_left = 0;
        held = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.status          = m_tdata[1:0];
                got.is_load         = m_tdata[2];
                got.access_address  = m_tdata[66:3];
                got.transfer_data   = m_tdata[130:67];
                got.target_register = m_tdata[135:131];
                sb.check_result(got, msgs);
                foreach (msgs[i]) flag_mismatch(msgs[i]);
            end
            if (hold_request && !held) begin
                held = 1;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 0;
            end else if (idle_left > 0) begin
                idle_left--;
                m_tready <= 0;
            end else begin
                idle_left = pick_gap();
                m_tready <= (idle_left == 0);
            end
        end
    end

    // run limit, sized for the memory clearing pass after reset
    initial begin
        #3000000;
        $display("load_store_unit test failed");
        $finish;
    end

    initial begin
        logic [31:0] ins;
        int r;
        repeat (7) @(posedge aclk);
        aresetn <= 1;

        // directed: encodings, wraps, write-back corners, memory edges
        send(32'h0000_0000, 64'd0);
        send(32'hFFFF_FFFF, 64'd0);
        send(mk_uimm(1, 0, 12'd0, 5'd31, 5'd31), 64'd0);
        send(mk_literal(1, 19'd0, 5'd1), 64'd0);
        send(mk_index(1, 1, 9'h0FF, 0, 5'd2, 5'd3), 64'd0);
        send(mk_index(1, 0, 9'd8, 1, 5'd2, 5'd2), 64'd0);
        send(mk_uimm(0, 1, 12'd0, 5'd2, 5'd5), 64'd0);
        send(mk_index(1, 1, 9'h1F8, 1, 5'd2, 5'd2), 64'd0);
        send(mk_regoff(0, 0, 5'd31, 5'd2, 5'd2), 64'd0);
        send(mk_literal(1, 19'd0, 5'd6), 64'(MEM_BYTES - 8));
        send(mk_literal(1, 19'd0, 5'd6), 64'(MEM_BYTES - 4));
        send(mk_literal(0, 19'd0, 5'd6), 64'(MEM_BYTES - 4));
        send(mk_literal(1, 19'd1, 5'd7), 64'hFFFF_FFFF_FFFF_FFFF);
        send(mk_literal(1, 19'h40000, 5'd7), 64'd0);
        send(mk_literal(1, 19'h7FFFF, 5'd7), 64'(MEM_BYTES - 1));
        send(mk_uimm(1, 0, 12'hFFF, 5'd31, 5'd3), 64'd0);
        send(mk_uimm(1, 1, 12'hFFF, 5'd31, 5'd8), 64'd0);
        send(mk_index(1, 0, 9'h100, 0, 5'd4, 5'd4), 64'd0);
        send(mk_index(1, 1, 9'h100, 1, 5'd4, 5'd9), 64'd0);
        send(mk_index(1, 1, 9'h0FF, 1, 5'd4, 5'd9), 64'd0);
        send(mk_regoff(1, 1, 5'd4, 5'd31, 5'd10), 64'd0);
        send(mk_regoff(1, 0, 5'd3, 5'd2, 5'd31), 64'd0);
        send(mk_index(1, 0, 9'd16, 1, 5'd31, 5'd31), 64'd0);

        // random: mostly well-formed transfers over a small register set
        repeat (550) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                ins = $urandom;
                ins[25] = 1;
                send(ins, {$urandom, $urandom});
            end else if (r < 30) begin
                send(mk_uimm($urandom, $urandom,
                             ($urandom_range(0, 7) == 0) ? 12'($urandom)
                                                         : 12'($urandom_range(0, 64)),
                             pick_reg(), pick_reg()), {$urandom, $urandom});
            end else if (r < 50) begin
                send(mk_regoff($urandom, $urandom, pick_reg(), pick_reg(), pick_reg()),
                     {$urandom, $urandom});
            end else if (r < 78) begin
                send(mk_index($urandom, $urandom, pick_simm(), $urandom,
                              pick_reg(), pick_reg()), {$urandom, $urandom});
            end else begin
                send(mk_literal($urandom, 19'($urandom), pick_reg()), pick_pc());
            end
        end
        s_tvalid <= 0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("load_store_unit test passed");
        end else begin
            $display("load_store_unit test failed");
        end
        $finish;
    end

endmodule
